// File: hdl/zbuffer_point_projector_macros.svh
// Assertion macros shared by the projector RTL.
`ifndef ZBUFFER_POINT_PROJECTOR_MACROS_SVH
`define ZBUFFER_POINT_PROJECTOR_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ZBPP_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("zbpp: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ZBPP_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("zbpp: next-cycle check failed");

`endif

// File: hdl/zbpp_pkg.sv
// Types and constants shared by the z-buffered point projector.
package zbpp_pkg;

   // Screen geometry and projection scale
   localparam int SCREEN_WIDTH     = 160;
   localparam int SCREEN_HEIGHT    = 44;
   localparam int PROJECTION_SCALE = 40;
   localparam int CELLS            = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COL_BASE         = SCREEN_WIDTH / 2;
   localparam int ROW_BASE         = SCREEN_HEIGHT / 2;
   localparam int COL_SCALE        = 2 * PROJECTION_SCALE;

   // Field and datapath widths
   localparam int IDX_W   = 13;
   localparam int CH_W    = 8;
   localparam int DEPTH_W = 24;
   localparam int WORD_W  = DEPTH_W + CH_W;
   localparam int FRAC_W  = 14;
   localparam int M_W     = 20;   // rotation matrix entry, Q.14
   localparam int C_W     = 32;   // rotated coordinate, Q.14
   localparam int N_W     = 42;   // projection numerator and quotient
   localparam int REQ_W   = 56;
   localparam int RSP_W   = 24;
   localparam int CSR_W   = 16;

   localparam logic [CH_W-1:0]    RESET_CHAR = 8'd46;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX  = '1;

   // Opcodes
   localparam logic OP_PLOT = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_SIN_A = 3'd0,
      CSR_COS_A = 3'd1,
      CSR_SIN_B = 3'd2,
      CSR_COS_B = 3'd3,
      CSR_SIN_C = 3'd4,
      CSR_COS_C = 3'd5,
      CSR_CAM   = 3'd6,
      CSR_BG    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] sin_a;
      logic signed [15:0] cos_a;
      logic signed [15:0] sin_b;
      logic signed [15:0] cos_b;
      logic signed [15:0] sin_c;
      logic signed [15:0] cos_c;
      logic [9:0]         cam;
      logic [CH_W-1:0]    bg;
   } cfg_type;

   // One classified request as it waits in the queue
   typedef struct packed {
      logic               opcode;
      logic signed [7:0]  px;
      logic signed [7:0]  py;
      logic signed [7:0]  pz;
      logic signed [7:0]  off;
      logic [CH_W-1:0]    ch;
      logic [IDX_W-1:0]   ridx;
      logic               ridx_ok;
   } item_type;

   // Result beat, read_char in the lowest bits
   typedef struct packed {
      logic             dropped;
      logic             updated;
      logic             on_screen;
      logic [IDX_W-1:0] pixel_index;
      logic [CH_W-1:0]  read_char;
   } result_type;

endpackage

// File: hdl/zbuffer_point_projector.sv
// Top level of the z-buffered point projector: registers, front, back, store.
//
//   channel | direction | payload
//   req_    | in        | tdata point/offset/char/read_index, tuser opcode
//   rsp_    | out       | tdata read_char/pixel_index/on_screen/updated/dropped
//   csr_    | in        | csr_index selects register, csr_data value
//
// A read is popped from the queue, looks up the store and registers its result at commit.
// A plot passes pop, transform, three divisions (column, row, depth: start, 42 quotient
// bits, done), index, lookup and commit; it skips the lookup when off screen and skips
// the divisions, index and lookup when the point is dropped. After reset the store is swept;
// req_tready stays low meanwhile.
// Two requests queue ahead of the back end; the result register holds a stalled beat.
// Register writes are taken in any cycle; write them only while no request is in flight.
`include "zbuffer_point_projector_macros.svh"

module zbuffer_point_projector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // x[7:0], y[15:8], z[23:16], offset[31:24], char[39:32], read_index[52:40]
   input  logic [zbpp_pkg::REQ_W-1:0]  req_tdata,
   // opcode[0]
   input  logic [0:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // read_char[7:0], pixel_index[20:8], on_screen[21], updated[22], dropped[23]
   output logic [zbpp_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [zbpp_pkg::CSR_W-1:0]  csr_data
);

   zbpp_pkg::cfg_type    cfg_ff, cfg_in;
   zbpp_pkg::item_type   q_item;
   zbpp_pkg::result_type rsp_view;
   logic q_valid, q_pop, clearing;
   logic wr_en;
   logic [zbpp_pkg::IDX_W-1:0]  wr_addr, rd_addr;
   logic [zbpp_pkg::WORD_W-1:0] wr_data, rd_data;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (zbpp_pkg::csr_index_type'(csr_index))
            zbpp_pkg::CSR_SIN_A: cfg_in.sin_a = csr_data;
            zbpp_pkg::CSR_COS_A: cfg_in.cos_a = csr_data;
            zbpp_pkg::CSR_SIN_B: cfg_in.sin_b = csr_data;
            zbpp_pkg::CSR_COS_B: cfg_in.cos_b = csr_data;
            zbpp_pkg::CSR_SIN_C: cfg_in.sin_c = csr_data;
            zbpp_pkg::CSR_COS_C: cfg_in.cos_c = csr_data;
            zbpp_pkg::CSR_CAM:   cfg_in.cam   = csr_data[9:0];
            zbpp_pkg::CSR_BG:    cfg_in.bg    = csr_data[zbpp_pkg::CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sin_a <= 16'sd0;
         cfg_ff.cos_a <= 16'sd16384;
         cfg_ff.sin_b <= 16'sd0;
         cfg_ff.cos_b <= 16'sd16384;
         cfg_ff.sin_c <= 16'sd0;
         cfg_ff.cos_c <= 16'sd16384;
         cfg_ff.cam   <= 10'd100;
         cfg_ff.bg    <= zbpp_pkg::RESET_CHAR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   zbpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   zbpp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   zbpp_ram #(
      .WIDTH (zbpp_pkg::WORD_W),
      .DEPTH (zbpp_pkg::CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_view = rsp_tdata;

   // Checks
   `ZBPP_ASSERT_IMP(a_clear_stall, clearing, !req_tready)
   `ZBPP_ASSERT_IMP(a_update_on_screen, rsp_tvalid && rsp_view.updated, rsp_view.on_screen && !rsp_view.dropped)
   `ZBPP_ASSERT_IMP(a_drop_quiet, rsp_tvalid && rsp_view.dropped, rsp_view.pixel_index == '0 && !rsp_view.on_screen)
   `ZBPP_ASSERT_NXT(a_bg_write, csr_valid && csr_ready && csr_index == zbpp_pkg::CSR_BG, cfg_ff.bg == $past(csr_data[7:0]))

endmodule

// File: hdl/zbpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module zbpp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 7040,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/zbpp_div.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
module zbpp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [zbpp_pkg::N_W-1:0]   dividend,
   input  logic [zbpp_pkg::C_W-1:0]   divisor,
   output logic                       done,
   output logic [zbpp_pkg::N_W-1:0]   quotient
);

   localparam int CW = $clog2(zbpp_pkg::N_W);

   logic [zbpp_pkg::N_W-1:0] quo_ff, quo_in;
   logic [zbpp_pkg::C_W-1:0] rem_ff, rem_in;
   logic [zbpp_pkg::C_W-1:0] div_ff, div_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [zbpp_pkg::C_W:0]   rem_shift;
   logic [zbpp_pkg::C_W:0]   rem_diff;

   // Shift in one dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, quo_ff[zbpp_pkg::N_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(zbpp_pkg::N_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_diff[zbpp_pkg::C_W-1:0];
            quo_in = {quo_ff[zbpp_pkg::N_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[zbpp_pkg::C_W-1:0];
            quo_in = {quo_ff[zbpp_pkg::N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/zbpp_front.sv
// Front end: accepts request beats, classifies them and queues them.
module zbpp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clearing,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // x[7:0], y[15:8], z[23:16], offset[31:24], char[39:32], read_index[52:40]
   input  logic [zbpp_pkg::REQ_W-1:0]   req_tdata,
   // opcode[0]
   input  logic [0:0]                   req_tuser,
   output logic                         q_valid,
   output zbpp_pkg::item_type           q_item,
   input  logic                         q_pop
);

   localparam int QD = 2;
   localparam int PW = $clog2(QD);

   zbpp_pkg::item_type q_mem_ff [QD];
   zbpp_pkg::item_type beat_item;
   logic [PW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]        count_ff;
   logic               push, pop;

   // Unpack and classify the incoming beat
   always_comb begin
      beat_item.opcode  = req_tuser[0];
      beat_item.px      = req_tdata[7:0];
      beat_item.py      = req_tdata[15:8];
      beat_item.pz      = req_tdata[23:16];
      beat_item.off     = req_tdata[31:24];
      beat_item.ch      = req_tdata[39:32];
      beat_item.ridx    = req_tdata[52:40];
      beat_item.ridx_ok = (req_tdata[52:40] < zbpp_pkg::IDX_W'(zbpp_pkg::CELLS));
   end

   assign req_tready = !clearing && (count_ff != (PW+1)'(QD));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = q_mem_ff[rd_ptr_ff];

   // Queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= beat_item;
      end
   end

endmodule

// File: hdl/zbpp_back.sv
// Back end: clears the screen store, transforms, projects and depth-tests, and serves reads.
module zbpp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  zbpp_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   input  zbpp_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          clearing,
   output logic                          wr_en,
   output logic [zbpp_pkg::IDX_W-1:0]    wr_addr,
   output logic [zbpp_pkg::WORD_W-1:0]   wr_data,
   output logic [zbpp_pkg::IDX_W-1:0]    rd_addr,
   input  logic [zbpp_pkg::WORD_W-1:0]   rd_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [zbpp_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int M_W   = zbpp_pkg::M_W;
   localparam int C_W   = zbpp_pkg::C_W;
   localparam int N_W   = zbpp_pkg::N_W;
   localparam int I_W   = N_W + 10;
   localparam int P_W   = 28;
   localparam int S_W   = 50;
   localparam int XFORM_STEPS = 6;
   localparam logic [N_W-1:0] DEPTH_NUM = N_W'(64'd1 << (zbpp_pkg::DEPTH_W + zbpp_pkg::FRAC_W));
   localparam logic signed [8:0] COL_BASE  = 9'(zbpp_pkg::COL_BASE);
   localparam logic signed [8:0] ROW_BASE  = 9'(zbpp_pkg::ROW_BASE);
   localparam logic signed [8:0] COL_SCALE = 9'(zbpp_pkg::COL_SCALE);
   localparam logic signed [8:0] ROW_SCALE = 9'(zbpp_pkg::PROJECTION_SCALE);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_XFORM  = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_INDEX  = 7'b0010000,
      ST_LOOKUP = 7'b0100000,
      ST_COMMIT = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      SEL_COL   = 2'd0,
      SEL_ROW   = 2'd1,
      SEL_DEPTH = 2'd2
   } div_sel_type;

   // Q.42 helpers: scale a pair product up, widen a triple product
   function automatic logic signed [S_W-1:0] sh14(input logic signed [31:0] p);
      return {{(S_W-46){p[31]}}, p, 14'd0};
   endfunction

   function automatic logic signed [S_W-1:0] ext48(input logic signed [47:0] t);
      return S_W'(t);
   endfunction

   // Round 42 fraction bits to 14, half up
   function automatic logic signed [M_W-1:0] rnd(input logic signed [S_W-1:0] v);
      logic signed [S_W-1:0] s;
      s = v + S_W'(64'd1 << 27);
      return s[28+M_W-1:28];
   endfunction

   state_type   state_ff, state_in;
   div_sel_type div_sel_ff, div_sel_in;
   logic [zbpp_pkg::IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [2:0]  step_ff, step_in;
   logic        div_run_ff, div_run_in;
   logic        rsp_valid_ff, rsp_valid_in;
   zbpp_pkg::result_type rsp_data_ff, rsp_data_in;
   zbpp_pkg::item_type   item_ff, item_in;
   logic [zbpp_pkg::IDX_W-1:0]   addr_ff, addr_in;
   logic        on_ff, on_in, drop_ff, drop_in;
   logic [zbpp_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic signed [N_W:0] col_ff, col_in, row_ff, row_in;

   // Transform stage registers
   logic signed [31:0] p_cbcc_ff, p_sasb_ff, p_casc_ff, p_sasc_ff, p_casb_ff;
   logic signed [31:0] p_cbsc_ff, p_cacc_ff, p_sacc_ff, p_sacb_ff, p_cacb_ff;
   logic signed [47:0] t_sasb_cc_ff, t_casb_cc_ff, t_sasb_sc_ff, t_casb_sc_ff;
   logic signed [M_W-1:0] m_ff [9];
   logic signed [M_W-1:0] m_in [9];
   logic signed [P_W-1:0] pr_ff [9];
   logic signed [7:0]     pt [3];
   logic signed [C_W-1:0] x_ff, y_ff, z_ff;
   logic signed [N_W-1:0] nx_ff, ny_ff;
   logic signed [8:0]     col_base;

   // Division and index
   logic              div_start, div_done;
   logic [N_W-1:0]    div_dividend, div_q;
   logic [N_W-1:0]    nx_mag, ny_mag;
   logic signed [N_W:0] q_signed;
   logic signed [I_W-1:0] idx;
   logic              idx_on;
   logic              slot_free;

   zbpp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (z_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Matrix terms and rotated coordinates, one step per register
   always_comb begin
      m_in[0] = rnd(sh14(p_cbcc_ff));
      m_in[1] = rnd(ext48(t_sasb_cc_ff) + sh14(p_casc_ff));
      m_in[2] = rnd(sh14(p_sasc_ff) - ext48(t_casb_cc_ff));
      m_in[3] = rnd(-sh14(p_cbsc_ff));
      m_in[4] = rnd(sh14(p_cacc_ff) - ext48(t_sasb_sc_ff));
      m_in[5] = rnd(sh14(p_sacc_ff) + ext48(t_casb_sc_ff));
      m_in[6] = M_W'(cfg.sin_b);
      m_in[7] = rnd(-sh14(p_sacb_ff));
      m_in[8] = rnd(sh14(p_cacb_ff));
      pt[0]   = item_ff.px;
      pt[1]   = item_ff.py;
      pt[2]   = item_ff.pz;
      col_base = COL_BASE + 9'(item_ff.off);
   end

   always_ff @(posedge clock) begin
      p_cbcc_ff <= 32'(cfg.cos_b) * 32'(cfg.cos_c);
      p_sasb_ff <= 32'(cfg.sin_a) * 32'(cfg.sin_b);
      p_casc_ff <= 32'(cfg.cos_a) * 32'(cfg.sin_c);
      p_sasc_ff <= 32'(cfg.sin_a) * 32'(cfg.sin_c);
      p_casb_ff <= 32'(cfg.cos_a) * 32'(cfg.sin_b);
      p_cbsc_ff <= 32'(cfg.cos_b) * 32'(cfg.sin_c);
      p_cacc_ff <= 32'(cfg.cos_a) * 32'(cfg.cos_c);
      p_sacc_ff <= 32'(cfg.sin_a) * 32'(cfg.cos_c);
      p_sacb_ff <= 32'(cfg.sin_a) * 32'(cfg.cos_b);
      p_cacb_ff <= 32'(cfg.cos_a) * 32'(cfg.cos_b);
      t_sasb_cc_ff <= 48'(p_sasb_ff) * 48'(cfg.cos_c);
      t_casb_cc_ff <= 48'(p_casb_ff) * 48'(cfg.cos_c);
      t_sasb_sc_ff <= 48'(p_sasb_ff) * 48'(cfg.sin_c);
      t_casb_sc_ff <= 48'(p_casb_ff) * 48'(cfg.sin_c);
      for (int e = 0; e < 9; e++) begin
         m_ff[e]  <= m_in[e];
         pr_ff[e] <= P_W'(pt[e % 3]) * P_W'(m_ff[e]);
      end
      x_ff <= C_W'(pr_ff[0]) + C_W'(pr_ff[1]) + C_W'(pr_ff[2]);
      y_ff <= C_W'(pr_ff[3]) + C_W'(pr_ff[4]) + C_W'(pr_ff[5]);
      z_ff <= C_W'(pr_ff[6]) + C_W'(pr_ff[7]) + C_W'(pr_ff[8])
            + $signed(C_W'({cfg.cam, 14'd0}));
      nx_ff <= N_W'(col_base) * N_W'(z_ff) + N_W'(COL_SCALE) * N_W'(x_ff);
      ny_ff <= N_W'(ROW_BASE) * N_W'(z_ff) + N_W'(ROW_SCALE) * N_W'(y_ff);
   end

   // Dividend select and signed quotient
   always_comb begin
      nx_mag = nx_ff[N_W-1] ? N_W'(-nx_ff) : N_W'(nx_ff);
      ny_mag = ny_ff[N_W-1] ? N_W'(-ny_ff) : N_W'(ny_ff);
      case (div_sel_ff)
         SEL_COL: div_dividend = nx_mag;
         SEL_ROW: div_dividend = ny_mag;
         default: div_dividend = DEPTH_NUM;
      endcase
      q_signed = $signed({1'b0, div_q});
      idx    = I_W'(col_ff) + I_W'(row_ff) * I_W'(zbpp_pkg::SCREEN_WIDTH);
      idx_on = !idx[I_W-1] && (idx < I_W'(zbpp_pkg::CELLS));
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      div_sel_in   = div_sel_ff;
      clr_cnt_in   = clr_cnt_ff;
      step_in      = step_ff;
      div_run_in   = div_run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      on_in        = on_ff;
      drop_in      = drop_ff;
      depth_in     = depth_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = {zbpp_pkg::DEPTH_W'(0), cfg.bg};
      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = {zbpp_pkg::DEPTH_W'(0), zbpp_pkg::RESET_CHAR};
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == zbpp_pkg::IDX_W'(zbpp_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               on_in   = 1'b0;
               drop_in = 1'b0;
               if (q_item.opcode == zbpp_pkg::OP_READ) begin
                  addr_in  = q_item.ridx;
                  state_in = ST_LOOKUP;
               end else begin
                  step_in  = '0;
                  state_in = ST_XFORM;
               end
            end
         end
         ST_XFORM: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'(XFORM_STEPS - 1)) begin
               div_sel_in = SEL_COL;
               div_run_in = 1'b0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_run_ff) begin
               if (div_sel_ff == SEL_COL && z_ff <= 32'sd0) begin
                  drop_in  = 1'b1;
                  state_in = ST_COMMIT;
               end else begin
                  div_start  = 1'b1;
                  div_run_in = 1'b1;
               end
            end else if (div_done) begin
               div_run_in = 1'b0;
               case (div_sel_ff)
                  SEL_COL: begin
                     col_in     = nx_ff[N_W-1] ? -q_signed : q_signed;
                     div_sel_in = SEL_ROW;
                  end
                  SEL_ROW: begin
                     row_in     = ny_ff[N_W-1] ? -q_signed : q_signed;
                     div_sel_in = SEL_DEPTH;
                  end
                  default: begin
                     depth_in = (|div_q[N_W-1:zbpp_pkg::DEPTH_W]) ? zbpp_pkg::DEPTH_MAX
                                : div_q[zbpp_pkg::DEPTH_W-1:0];
                     state_in = ST_INDEX;
                  end
               endcase
            end
         end
         ST_INDEX: begin
            addr_in  = idx[zbpp_pkg::IDX_W-1:0];
            on_in    = idx_on;
            state_in = idx_on ? ST_LOOKUP : ST_COMMIT;
         end
         ST_LOOKUP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (item_ff.opcode == zbpp_pkg::OP_READ) begin
                  if (item_ff.ridx_ok) begin
                     rsp_data_in.read_char = rd_data[zbpp_pkg::CH_W-1:0];
                     wr_en = 1'b1;
                  end
               end else if (drop_ff) begin
                  rsp_data_in.dropped = 1'b1;
               end else if (on_ff) begin
                  rsp_data_in.on_screen   = 1'b1;
                  rsp_data_in.pixel_index = addr_ff;
                  if (depth_ff > rd_data[zbpp_pkg::WORD_W-1:zbpp_pkg::CH_W]) begin
                     rsp_data_in.updated = 1'b1;
                     wr_en   = 1'b1;
                     wr_data = {depth_ff, item_ff.ch};
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         div_sel_ff   <= SEL_COL;
         clr_cnt_ff   <= '0;
         step_ff      <= '0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_sel_ff   <= div_sel_in;
         clr_cnt_ff   <= clr_cnt_in;
         step_ff      <= step_in;
         div_run_ff   <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      on_ff       <= on_in;
      drop_ff     <= drop_in;
      depth_ff    <= depth_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
   end

   assign clearing   = (state_ff == ST_CLEAR);
   assign rd_addr    = addr_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the z-buffered point projector.
module testbench;

   typedef struct {
      bit              op;
      bit signed [7:0] px;
      bit signed [7:0] py;
      bit signed [7:0] pz;
      bit signed [7:0] off;
      bit [7:0]        ch;
      bit [12:0]       ridx;
   } point_req_type;

   typedef struct {
      bit [7:0]  read_char;
      bit [12:0] pixel_index;
      bit        on_screen;
      bit        updated;
      bit        dropped;
   } plot_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [zbpp_pkg::REQ_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [zbpp_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [zbpp_pkg::CSR_W-1:0] csr_data = '0;

   // Shadow of the registers and the two stores
   longint sin_a, cos_a, sin_b, cos_b, sin_c, cos_c, cam_dist;
   bit [7:0] bg_char;
   bit [23:0] depth_mem[zbpp_pkg::CELLS];
   bit [7:0] char_mem[zbpp_pkg::CELLS];

   point_req_type pending_points[$];
   plot_result_type expected_results[$];
   int hit_cells[$];
   int issued_beats = 0, accepted_beats = 0;
   int burst_left = 0, gap_left = 0;
   int stall_mode = 0, stall_phase = 0;
   int mismatches = 0;
   longint cycles = 0;

   zbuffer_point_projector dut (.*);

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   function automatic longint round_q14(input longint v);
      return (v + (64'sd1 <<< 27)) >>> 28;
   endfunction

   // Rotate, project and depth-test a plot beat, or serve a read beat, against the shadow stores
   function automatic plot_result_type project_point(input point_req_type p);
      plot_result_type r;
      longint s, m00, m01, m02, m10, m11, m12, m20, m21, m22;
      longint x, y, z, nx, ny, col, row, idx, dq;
      bit [23:0] depth;
      r = '{default: 0};
      s = 64'sd1 <<< 14;
      if (p.op == zbpp_pkg::OP_READ) begin
         if (p.ridx < zbpp_pkg::CELLS) begin
            r.read_char = char_mem[p.ridx];
            char_mem[p.ridx] = bg_char;
            depth_mem[p.ridx] = '0;
         end
         return r;
      end
      m00 = round_q14(cos_b * cos_c * s);
      m01 = round_q14(sin_a * sin_b * cos_c + cos_a * sin_c * s);
      m02 = round_q14(sin_a * sin_c * s - cos_a * sin_b * cos_c);
      m10 = round_q14(-cos_b * sin_c * s);
      m11 = round_q14(cos_a * cos_c * s - sin_a * sin_b * sin_c);
      m12 = round_q14(sin_a * cos_c * s + cos_a * sin_b * sin_c);
      m20 = round_q14(sin_b * s * s);
      m21 = round_q14(-sin_a * cos_b * s);
      m22 = round_q14(cos_a * cos_b * s);
      x = p.px * m00 + p.py * m01 + p.pz * m02;
      y = p.px * m10 + p.py * m11 + p.pz * m12;
      z = p.px * m20 + p.py * m21 + p.pz * m22 + cam_dist * s;
      if (z <= 0) begin
         r.dropped = 1'b1;
         return r;
      end
      nx = (zbpp_pkg::COL_BASE + longint'(p.off)) * z + zbpp_pkg::COL_SCALE * x;
      ny = zbpp_pkg::ROW_BASE * z + zbpp_pkg::PROJECTION_SCALE * y;
      col = nx / z;
      row = ny / z;
      idx = col + row * zbpp_pkg::SCREEN_WIDTH;
      dq = (64'sd1 <<< 38) / z;
      depth = (dq > 64'sd16777215) ? 24'hFFFFFF : dq[23:0];
      if (idx >= 0 && idx < zbpp_pkg::CELLS) begin
         r.on_screen = 1'b1;
         r.pixel_index = idx[12:0];
         if (depth > depth_mem[idx]) begin
            depth_mem[idx] = depth;
            char_mem[idx] = p.ch;
            r.updated = 1'b1;
         end
      end
      return r;
   endfunction

   // Sample accepted beats, predict, and check results
   always @(posedge clock) begin
      point_req_type p;
      plot_result_type want, got;
      cycles++;
      if (cycles > 2000000) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         if (!reset && req_tvalid && req_tready) begin
            p.op = req_tuser[0];
            p.px = req_tdata[7:0];
            p.py = req_tdata[15:8];
            p.pz = req_tdata[23:16];
            p.off = req_tdata[31:24];
            p.ch = req_tdata[39:32];
            p.ridx = req_tdata[52:40];
            want = project_point(p);
            expected_results.push_back(want);
            if (want.on_screen) begin
               hit_cells.push_back(want.pixel_index);
               if (hit_cells.size() > 64) void'(hit_cells.pop_front());
            end
            accepted_beats++;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.read_char = rsp_tdata[7:0];
            got.pixel_index = rsp_tdata[20:8];
            got.on_screen = rsp_tdata[21];
            got.updated = rsp_tdata[22];
            got.dropped = rsp_tdata[23];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.read_char != want.read_char)
                  report_mismatch("read_char", got.read_char, want.read_char);
               if (got.pixel_index != want.pixel_index)
                  report_mismatch("pixel_index", got.pixel_index, want.pixel_index);
               if (got.on_screen != want.on_screen)
                  report_mismatch("on_screen", got.on_screen, want.on_screen);
               if (got.updated != want.updated)
                  report_mismatch("updated", got.updated, want.updated);
               if (got.dropped != want.dropped)
                  report_mismatch("dropped", got.dropped, want.dropped);
            end
         end
      end
   end

   // Drive request beats in bursts with random gaps
   always @(negedge clock) begin
      point_req_type p;
      if (reset || (req_tvalid && accepted_beats != issued_beats)) begin
         // hold the current beat
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
         p = pending_points.pop_front();
         req_tuser <= p.op;
         req_tdata <= {3'b0, p.ridx, p.ch, p.off, p.pz, p.py, p.px};
         req_tvalid <= 1'b1;
         issued_beats++;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Stall the result side on a changing pattern
   always @(negedge clock) begin
      stall_phase++;
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_phase % 7) < 3;
      endcase
   end

   task automatic write_reg(input zbpp_pkg::csr_index_type ri, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= ri;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (ri)
         zbpp_pkg::CSR_SIN_A: sin_a = longint'(signed'(value));
         zbpp_pkg::CSR_COS_A: cos_a = longint'(signed'(value));
         zbpp_pkg::CSR_SIN_B: sin_b = longint'(signed'(value));
         zbpp_pkg::CSR_COS_B: cos_b = longint'(signed'(value));
         zbpp_pkg::CSR_SIN_C: sin_c = longint'(signed'(value));
         zbpp_pkg::CSR_COS_C: cos_c = longint'(signed'(value));
         zbpp_pkg::CSR_CAM: cam_dist = value[9:0];
         default: bg_char = value[7:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_angles(input logic [15:0] sa, ca, sb, cb, sc, cc);
      write_reg(zbpp_pkg::CSR_SIN_A, sa);
      write_reg(zbpp_pkg::CSR_COS_A, ca);
      write_reg(zbpp_pkg::CSR_SIN_B, sb);
      write_reg(zbpp_pkg::CSR_COS_B, cb);
      write_reg(zbpp_pkg::CSR_SIN_C, sc);
      write_reg(zbpp_pkg::CSR_COS_C, cc);
   endtask

   task automatic queue_point(input bit op, input int x, y, z, o, input int c, input int ri);
      point_req_type p;
      p.op = op;
      p.px = 8'(x);
      p.py = 8'(y);
      p.pz = 8'(z);
      p.off = 8'(o);
      p.ch = 8'(c);
      p.ridx = 13'(ri);
      pending_points.push_back(p);
   endtask

   task automatic wait_drained();
      wait (pending_points.size() == 0 && accepted_beats == issued_beats);
      wait (expected_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // Mostly small plots near the screen, some full-range, a quarter reads
   task automatic queue_random(input int count);
      int sel, span;
      for (int n = 0; n < count; n++) begin
         wait (pending_points.size() < 4);
         sel = $urandom_range(0, 99);
         span = ($urandom_range(0, 9) < 7) ? 40 : 128;
         if (sel < 12 && hit_cells.size() > 0)
            queue_point(zbpp_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                        hit_cells[$urandom_range(0, hit_cells.size() - 1)]);
         else if (sel < 25)
            queue_point(zbpp_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 8191));
         else if (span == 40)
            queue_point(zbpp_pkg::OP_PLOT, $urandom_range(0, 80) - 40,
                        $urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
                        $urandom_range(0, 60) - 30, $urandom, $urandom);
         else
            queue_point(zbpp_pkg::OP_PLOT, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
      end
   endtask

   initial begin
      sin_a = 0; cos_a = 16384; sin_b = 0; cos_b = 16384; sin_c = 0; cos_c = 16384;
      cam_dist = 100;
      bg_char = zbpp_pkg::RESET_CHAR;
      foreach (char_mem[i]) char_mem[i] = zbpp_pkg::RESET_CHAR;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: center, extremes, ties, wins, reads at the index limits
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, 0, 0, 8'h41, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, 0, 0, 8'h42, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, -5, 0, 8'h43, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, 5, 0, 8'h44, 0);
      queue_point(zbpp_pkg::OP_PLOT, 127, 127, 127, 127, 8'hFF, 8191);
      queue_point(zbpp_pkg::OP_PLOT, -128, -128, -128, -128, 8'h00, 0);
      queue_point(zbpp_pkg::OP_PLOT, 10, -10, 0, -80, 8'h55, 0);
      queue_point(zbpp_pkg::OP_PLOT, -10, 10, 0, 79, 8'hAA, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 50, 0, 0, 8'h30, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, -55, 0, 0, 8'h31, 0);
      queue_point(zbpp_pkg::OP_READ, 0, 0, 0, 0, 0, 22 * zbpp_pkg::SCREEN_WIDTH + 80);
      queue_point(zbpp_pkg::OP_READ, 0, 0, 0, 0, 0, 22 * zbpp_pkg::SCREEN_WIDTH + 80);
      queue_point(zbpp_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
      queue_point(zbpp_pkg::OP_READ, 0, 0, 0, 0, 0, zbpp_pkg::CELLS - 1);
      queue_point(zbpp_pkg::OP_READ, 0, 0, 0, 0, 0, zbpp_pkg::CELLS);
      queue_point(zbpp_pkg::OP_READ, 127, 127, 127, 127, 255, 8191);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, -99, 0, 8'h21, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, -100, 0, 8'h22, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, -128, 0, 8'h23, 0);
      queue_random(100);
      wait_drained();

      // Rotated views, camera and background at both ends
      write_reg(zbpp_pkg::CSR_BG, 16'h00FF);
      write_reg(zbpp_pkg::CSR_CAM, 16'd1);
      set_angles(16'd11585, 16'd11585, 16'd6270, 16'd15137, -16'sd8192, 16'd14189);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, 0, 0, 8'h61, 0);
      queue_point(zbpp_pkg::OP_PLOT, 0, 0, 1, 0, 8'h62, 0);
      queue_random(100);
      wait_drained();

      write_reg(zbpp_pkg::CSR_CAM, 16'd1023);
      write_reg(zbpp_pkg::CSR_BG, 16'h0000);
      set_angles(16'd16384, -16'sd16384, 16'd16384, -16'sd16384, 16'd16384, -16'sd16384);
      queue_random(100);
      wait_drained();

      write_reg(zbpp_pkg::CSR_CAM, 16'd40);
      set_angles(-16'sd16384, 16'd0, -16'sd16384, 16'd0, -16'sd16384, 16'd0);
      queue_random(100);
      wait_drained();

      // Register values outside the nominal range, camera at zero
      write_reg(zbpp_pkg::CSR_CAM, 16'd0);
      write_reg(zbpp_pkg::CSR_BG, 16'd46);
      set_angles(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000);
      queue_random(50);
      wait_drained();

      for (int k = 0; k < 2; k++) begin
         write_reg(zbpp_pkg::CSR_CAM, 16'($urandom_range(30, 300)));
         write_reg(zbpp_pkg::CSR_BG, 16'($urandom));
         set_angles(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384));
         queue_random(75);
         wait_drained();
      end

      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/zbpp_pkg.sv
hdl/zbpp_ram.sv
hdl/zbpp_div.sv
hdl/zbpp_front.sv
hdl/zbpp_back.sv
hdl/zbuffer_point_projector.sv
sim/testbench.sv
